@@ src/frhl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frhl_pkg
// Types and codes shared by the fault registry and its health indicator.
// ----------------------------------------------------------------------------
package frhl_pkg;

	localparam int FAULT_SLOTS_DEF = 16;
	localparam int SLOTS_MAX       = 64;
	localparam int IDX_W           = $clog2(SLOTS_MAX);
	localparam int SRC_W           = 8;
	localparam int KIND_W          = 4;
	localparam int STAMP_W         = 48;
	localparam int NUM_W           = 32;
	localparam int SLOT_OUT_W      = 4;

	typedef enum logic [1:0] {
		CMD_REGISTER  = 2'd0,
		CMD_CLEAR     = 2'd1,
		CMD_FLUSH     = 2'd2,
		CMD_FLUSH_ALT = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		SEV_INFO  = 2'd0,
		SEV_WARN  = 2'd1,
		SEV_CRIT  = 2'd2,
		SEV_OTHER = 2'd3
	} sev_t;

	typedef enum logic [1:0] {
		LED_OK     = 2'd0,
		LED_AMBER  = 2'd1,
		LED_RED    = 2'd2,
		LED_SPARE  = 2'd3
	} led_t;

	typedef enum logic [2:0] {
		OUT_NEW       = 3'd0,
		OUT_REFRESHED = 3'd1,
		OUT_DROPPED   = 3'd2,
		OUT_CLEARED   = 3'd3,
		OUT_NO_MATCH  = 3'd4,
		OUT_ALL_CLEAR = 3'd5
	} outcome_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Item travelling down the row of slot cells.
	typedef struct packed {
		logic                active;
		cmd_t                command;
		logic [SRC_W-1:0]    source_id;
		logic [KIND_W-1:0]   fault_kind;
		logic [STAMP_W-1:0]  time_stamp;
		logic                hit;
		logic [NUM_W-1:0]    hit_number;
		logic [IDX_W-1:0]    hit_idx;
		logic                free_found;
		logic [IDX_W-1:0]    free_idx;
		logic                crit;
		logic                warn;
	} pkt_t;

	// Broadcast write of a new entry.
	typedef struct packed {
		logic                en;
		logic [IDX_W-1:0]    idx;
		logic [SRC_W-1:0]    source_id;
		logic [KIND_W-1:0]   fault_kind;
		logic [1:0]          severity;
		logic [STAMP_W-1:0]  time_stamp;
		logic [NUM_W-1:0]    number;
	} wr_t;

endpackage
`default_nettype wire

@@ src/frhl_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frhl_req_if
// Request channel: one fault command per item.
// ----------------------------------------------------------------------------
interface frhl_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    command;
	logic [frhl_pkg::SRC_W-1:0]    source_id;
	logic [frhl_pkg::KIND_W-1:0]   fault_kind;
	logic [1:0]                    severity;
	logic [frhl_pkg::STAMP_W-1:0]  time_stamp;

	modport source (output valid, command, source_id, fault_kind, severity, time_stamp,
		input ready);
	modport sink (input valid, command, source_id, fault_kind, severity, time_stamp,
		output ready);
endinterface
`default_nettype wire

@@ src/frhl_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frhl_rsp_if
// Response channel: indicator and outcome per item.
// ----------------------------------------------------------------------------
interface frhl_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       health_led;
	logic [2:0]                       outcome;
	logic [frhl_pkg::NUM_W-1:0]       fault_number;
	logic [frhl_pkg::SLOT_OUT_W-1:0]  slot_index;

	modport source (output valid, health_led, outcome, fault_number, slot_index,
		input ready);
	modport sink (input valid, health_led, outcome, fault_number, slot_index,
		output ready);
endinterface
`default_nettype wire

@@ src/frhl_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frhl_cell
// One fault slot: matches, refreshes and clears as the item passes by.
// ----------------------------------------------------------------------------
module frhl_cell #(
	parameter int INDEX = 0
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire frhl_pkg::pkt_t   pkt_i,
	input  wire frhl_pkg::wr_t    wr_i,
	output frhl_pkg::pkt_t        pkt_q
);

	localparam int IW = frhl_pkg::IDX_W;
	localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

	logic                            valid_q;
	logic [frhl_pkg::SRC_W-1:0]      source_q;
	logic [frhl_pkg::KIND_W-1:0]     kind_q;
	logic [1:0]                      sev_q;
	logic [frhl_pkg::STAMP_W-1:0]    stamp_q;
	logic [frhl_pkg::NUM_W-1:0]      number_q;

	logic            match;
	logic            wr_hit;
	logic            is_clear_all;
	frhl_pkg::pkt_t  pkt_d;

	assign match        = valid_q && (source_q == pkt_i.source_id) && (kind_q == pkt_i.fault_kind);
	assign wr_hit       = wr_i.en && (wr_i.idx == MY_IDX);
	assign is_clear_all = (pkt_i.command == frhl_pkg::CMD_FLUSH) ||
		(pkt_i.command == frhl_pkg::CMD_FLUSH_ALT);

	always_comb begin
		pkt_d = pkt_i;
		if (pkt_i.active) begin
			case (pkt_i.command)
				frhl_pkg::CMD_REGISTER: begin
					if (match) begin
						pkt_d.hit        = 1'b1;
						pkt_d.hit_number = number_q;
						pkt_d.hit_idx    = MY_IDX;
					end
					if (!valid_q && !pkt_i.free_found) begin
						pkt_d.free_found = 1'b1;
						pkt_d.free_idx   = MY_IDX;
					end
				end
				frhl_pkg::CMD_CLEAR: begin
					if (match) begin
						pkt_d.hit = 1'b1;
					end else if (valid_q) begin
						if (sev_q == frhl_pkg::SEV_CRIT) pkt_d.crit = 1'b1;
						if (sev_q == frhl_pkg::SEV_WARN) pkt_d.warn = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pkt_q   <= '0;
		end else begin
			pkt_q <= pkt_d;
			if (wr_hit) begin
				valid_q <= 1'b1;
			end else if (pkt_i.active) begin
				if (is_clear_all) valid_q <= 1'b0;
				else if (pkt_i.command == frhl_pkg::CMD_CLEAR && match) valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			source_q <= wr_i.source_id;
			kind_q   <= wr_i.fault_kind;
			sev_q    <= wr_i.severity;
			stamp_q  <= wr_i.time_stamp;
			number_q <= wr_i.number;
		end else if (pkt_i.active && pkt_i.command == frhl_pkg::CMD_REGISTER && match) begin
			stamp_q <= pkt_i.time_stamp;
		end
	end

endmodule
`default_nettype wire

@@ src/fault_registry_health_led.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fault_registry_health_led
// Fault slot table with a green / yellow / red health indicator.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   command, source_id, fault_kind, severity, time_stamp
//   rsp      out  valid/ready   health_led, outcome, fault_number, slot_index
//
// An item walks the row of slot cells one cell a cycle, then is captured in the
// tail register and finished in the done state. One item is in flight at a
// time; req is ready again once the result is in the output register. A
// stalled rsp holds the result and the next item. Reset empties the table,
// zeroes the sequence counter and shows green.
// ----------------------------------------------------------------------------
module fault_registry_health_led #(
	parameter int FAULT_SLOTS = frhl_pkg::FAULT_SLOTS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	frhl_req_if.sink          req,
	frhl_rsp_if.source        rsp
);

	frhl_pkg::state_t  state_q, state_d;
	frhl_pkg::pkt_t    chain [FAULT_SLOTS+1];
	frhl_pkg::pkt_t    tail_q;
	frhl_pkg::wr_t     wr;

	logic                            accept;
	logic                            finish;
	logic [frhl_pkg::NUM_W-1:0]      seq_q, seq_d;
	logic [1:0]                      led_q, led_d;
	logic [2:0]                      outcome_d;
	logic [frhl_pkg::NUM_W-1:0]      number_d;
	logic [frhl_pkg::SLOT_OUT_W-1:0] slot_d;
	logic [1:0]                      sev_hold_q;

	logic                            out_valid_q;
	logic [1:0]                      out_led_q;
	logic [2:0]                      out_outcome_q;
	logic [frhl_pkg::NUM_W-1:0]      out_number_q;
	logic [frhl_pkg::SLOT_OUT_W-1:0] out_slot_q;

	assign req.ready = (state_q == frhl_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign finish    = (state_q == frhl_pkg::ST_DONE) && (!out_valid_q || rsp.ready);

	always_comb begin
		chain[0]            = '0;
		chain[0].active     = accept;
		chain[0].command    = frhl_pkg::cmd_t'(req.command);
		chain[0].source_id  = req.source_id;
		chain[0].fault_kind = req.fault_kind;
		chain[0].time_stamp = req.time_stamp;
	end

	for (genvar g = 0; g < FAULT_SLOTS; g++) begin : g_cell
		frhl_cell #(.INDEX(g)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.pkt_i  (chain[g]),
			.wr_i   (wr),
			.pkt_q  (chain[g+1])
		);
	end

	always_comb begin
		state_d   = state_q;
		seq_d     = seq_q;
		led_d     = led_q;
		outcome_d = frhl_pkg::OUT_DROPPED;
		number_d  = '0;
		slot_d    = '0;
		wr            = '0;
		wr.idx        = tail_q.free_idx;
		wr.source_id  = tail_q.source_id;
		wr.fault_kind = tail_q.fault_kind;
		wr.severity   = sev_hold_q;
		wr.time_stamp = tail_q.time_stamp;
		wr.number     = seq_q + frhl_pkg::NUM_W'(1);

		case (tail_q.command) inside
			frhl_pkg::CMD_FLUSH, frhl_pkg::CMD_FLUSH_ALT: begin
				led_d     = frhl_pkg::LED_OK;
				outcome_d = frhl_pkg::OUT_ALL_CLEAR;
			end
			frhl_pkg::CMD_CLEAR: begin
				led_d     = tail_q.crit ? frhl_pkg::LED_RED :
					(tail_q.warn ? frhl_pkg::LED_AMBER : frhl_pkg::LED_OK);
				outcome_d = tail_q.hit ? frhl_pkg::OUT_CLEARED : frhl_pkg::OUT_NO_MATCH;
			end
			default: begin
				if (tail_q.hit) begin
					outcome_d = frhl_pkg::OUT_REFRESHED;
					number_d  = tail_q.hit_number;
					slot_d    = tail_q.hit_idx[frhl_pkg::SLOT_OUT_W-1:0];
				end else if (tail_q.free_found) begin
					outcome_d = frhl_pkg::OUT_NEW;
					seq_d     = wr.number;
					number_d  = wr.number;
					slot_d    = tail_q.free_idx[frhl_pkg::SLOT_OUT_W-1:0];
					wr.en     = 1'b1;
					if (sev_hold_q == frhl_pkg::SEV_CRIT)
						led_d = frhl_pkg::LED_RED;
					else if (sev_hold_q == frhl_pkg::SEV_WARN && led_q != frhl_pkg::LED_RED)
						led_d = frhl_pkg::LED_AMBER;
				end
			end
		endcase

		unique case (state_q)
			frhl_pkg::ST_IDLE: if (accept) state_d = frhl_pkg::ST_SCAN;
			frhl_pkg::ST_SCAN: if (chain[FAULT_SLOTS].active) state_d = frhl_pkg::ST_DONE;
			frhl_pkg::ST_DONE: if (finish) state_d = frhl_pkg::ST_IDLE;
			default:           state_d = frhl_pkg::ST_IDLE;
		endcase

		if (!finish) begin
			wr.en = 1'b0;
			seq_d = seq_q;
			led_d = led_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= frhl_pkg::ST_IDLE;
			seq_q       <= '0;
			led_q       <= frhl_pkg::LED_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			seq_q   <= seq_d;
			led_q   <= led_d;
			if (finish) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) sev_hold_q <= req.severity;
		if (state_q == frhl_pkg::ST_SCAN && chain[FAULT_SLOTS].active) tail_q <= chain[FAULT_SLOTS];
		if (finish) begin
			out_led_q     <= led_d;
			out_outcome_q <= outcome_d;
			out_number_q  <= number_d;
			out_slot_q    <= slot_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.health_led   = out_led_q;
	assign rsp.outcome      = out_outcome_q;
	assign rsp.fault_number = out_number_q;
	assign rsp.slot_index   = out_slot_q;

endmodule
`default_nettype wire
